### hw/rtl/operator_lexer_stream_top_macros.svh
// Assertion macros shared by the RTL files.
// Each check is sampled on clk and is off while rst_n is low.
`ifndef OPERATOR_LEXER_STREAM_TOP_MACROS_SVH
`define OPERATOR_LEXER_STREAM_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define OLX_CHECK(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("check failed");
`define OLX_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication failed");
`else
`define OLX_CHECK(lbl, expr)
`define OLX_IMPLY(lbl, ante, cons)
`endif
`endif

### hw/rtl/olx_pkg.sv
package olx_pkg;

  localparam int NEST_BITS_DEF     = 8;
  localparam int POSITION_BITS_DEF = 16;
  localparam int MAX_EVENTS        = 4;

  typedef logic [5:0] tok_t;

  typedef enum logic [3:0] {
    MD_IDLE, MD_OP, MD_DOT2, MD_LINE, MD_QUOTE, MD_BLOCK, MD_STR, MD_NUM, MD_IDENT,
    MD_CHRSEQ
  } mode_t;

  localparam logic [1:0] EV_BEGIN = 2'd0;
  localparam logic [1:0] EV_TEXT  = 2'd1;
  localparam logic [1:0] EV_END   = 2'd2;

  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_VT    = 8'd11;
  localparam logic [7:0] CH_FF    = 8'd12;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_TICK  = 8'h60;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_SQ    = 8'h27;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_USCORE = 8'h5F;

  localparam tok_t TK_EOF      = 6'd0;
  localparam tok_t TK_LINE_END = 6'd1;
  localparam tok_t TK_SEMI     = 6'd2;
  localparam tok_t TK_COMMA    = 6'd3;
  localparam tok_t TK_DOLLAR   = 6'd4;
  localparam tok_t TK_LBRACK   = 6'd5;
  localparam tok_t TK_RBRACK   = 6'd6;
  localparam tok_t TK_LBRACE   = 6'd7;
  localparam tok_t TK_RBRACE   = 6'd8;
  localparam tok_t TK_LPAREN   = 6'd9;
  localparam tok_t TK_RPAREN   = 6'd10;
  localparam tok_t TK_EQ       = 6'd11;
  localparam tok_t TK_QUEST    = 6'd13;
  localparam tok_t TK_BANG     = 6'd15;
  localparam tok_t TK_TILDE    = 6'd17;
  localparam tok_t TK_STAR     = 6'd19;
  localparam tok_t TK_AT       = 6'd21;
  localparam tok_t TK_LT       = 6'd23;
  localparam tok_t TK_GT       = 6'd26;
  localparam tok_t TK_PIPE     = 6'd29;
  localparam tok_t TK_AMP      = 6'd32;
  localparam tok_t TK_PLUS     = 6'd35;
  localparam tok_t TK_PCT      = 6'd38;
  localparam tok_t TK_CARET    = 6'd41;
  localparam tok_t TK_COLON    = 6'd44;
  localparam tok_t TK_DEC      = 6'd47;
  localparam tok_t TK_SUB_EQ   = 6'd48;
  localparam tok_t TK_ARROW    = 6'd49;
  localparam tok_t TK_MINUS    = 6'd50;
  localparam tok_t TK_DIV_EQ   = 6'd51;
  localparam tok_t TK_LINE_CMT = 6'd52;
  localparam tok_t TK_BLK_CMT  = 6'd53;
  localparam tok_t TK_SLASH    = 6'd54;
  localparam tok_t TK_DOT2     = 6'd55;
  localparam tok_t TK_DOT3     = 6'd56;
  localparam tok_t TK_DOT      = 6'd57;
  localparam tok_t TK_QUOTE    = 6'd58;
  localparam tok_t TK_CHAR     = 6'd59;
  localparam tok_t TK_STRING   = 6'd60;
  localparam tok_t TK_NUMBER   = 6'd61;
  localparam tok_t TK_IDENT    = 6'd62;
  localparam tok_t TK_CHRSEQ   = 6'd63;

  typedef struct packed {
    logic [1:0]  ek;
    tok_t        tk;
    logic [7:0]  tb;
    logic [15:0] ln;
    logic [15:0] cl;
    logic        last;
  } ev_t;

  typedef struct packed {
    ev_t [MAX_EVENTS-1:0] evs;
    logic [2:0]           cnt;
  } res_t;

  typedef struct packed {
    logic found;
    logic three;
    tok_t kind;
  } opb_t;

  function automatic opb_t op_base(input logic [7:0] c);
    opb_t r;
    r = '{found: 1'b1, three: 1'b0, kind: TK_EOF};
    case (c)
      8'h3D: r.kind = TK_EQ;
      8'h3F: r.kind = TK_QUEST;
      8'h21: r.kind = TK_BANG;
      8'h7E: r.kind = TK_TILDE;
      8'h2A: r.kind = TK_STAR;
      8'h40: r.kind = TK_AT;
      8'h3C: begin r.kind = TK_LT;    r.three = 1'b1; end
      8'h3E: begin r.kind = TK_GT;    r.three = 1'b1; end
      8'h7C: begin r.kind = TK_PIPE;  r.three = 1'b1; end
      8'h26: begin r.kind = TK_AMP;   r.three = 1'b1; end
      8'h2B: begin r.kind = TK_PLUS;  r.three = 1'b1; end
      8'h25: begin r.kind = TK_PCT;   r.three = 1'b1; end
      8'h5E: begin r.kind = TK_CARET; r.three = 1'b1; end
      8'h3A: begin r.kind = TK_COLON; r.three = 1'b1; end
      default: r.found = 1'b0;
    endcase
    return r;
  endfunction

  function automatic opb_t single_kind(input logic [7:0] c);
    opb_t r;
    r = '{found: 1'b1, three: 1'b0, kind: TK_EOF};
    case (c)
      8'h3B: r.kind = TK_SEMI;
      8'h2C: r.kind = TK_COMMA;
      8'h24: r.kind = TK_DOLLAR;
      8'h5B: r.kind = TK_LBRACK;
      8'h5D: r.kind = TK_RBRACK;
      8'h7B: r.kind = TK_LBRACE;
      8'h7D: r.kind = TK_RBRACE;
      8'h28: r.kind = TK_LPAREN;
      8'h29: r.kind = TK_RPAREN;
      default: r.found = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_ident(input logic [7:0] c);
    return is_digit(c) || ((c >= 8'h61) && (c <= 8'h7A)) ||
           ((c >= 8'h41) && (c <= 8'h5A)) || (c == CH_USCORE);
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SP) || (c == CH_TAB) || (c == CH_VT) || (c == CH_FF);
  endfunction

  function automatic tok_t mode_kind(input mode_t md, input logic [7:0] qc);
    tok_t k;
    case (md)
      MD_LINE:   k = TK_LINE_CMT;
      MD_QUOTE:  k = TK_QUOTE;
      MD_BLOCK:  k = TK_BLK_CMT;
      MD_STR:    k = (qc == CH_SQ) ? TK_CHAR : TK_STRING;
      MD_NUM:    k = TK_NUMBER;
      MD_IDENT:  k = TK_IDENT;
      MD_CHRSEQ: k = TK_CHRSEQ;
      default:   k = TK_EOF;
    endcase
    return k;
  endfunction

endpackage

### hw/rtl/olx_lexer.sv
`include "operator_lexer_stream_top_macros.svh"

module olx_lexer #(
  parameter int NEST_BITS     = 8,
  parameter int POSITION_BITS = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          fire,
  input  logic [7:0]    char_code,
  input  logic          end_of_input,
  output olx_pkg::res_t res
);
  import olx_pkg::*;

  localparam logic [POSITION_BITS-1:0] PMAX = '1;
  localparam logic [NEST_BITS-1:0]     NMAX = '1;

  mode_t                    md_r, md;
  logic [7:0]               hc_r, hc, qc_r, qc, ch, h;
  logic [NEST_BITS-1:0]     dp_r, dp;
  logic [POSITION_BITS-1:0] lc_r, lc, cc_r, cc;
  logic                     cp_r, cp;
  ev_t                      evs [8];
  logic [2:0]               n;
  logic                     gi, done, matched, stop, skip;
  tok_t                     k;
  opb_t                     ob, sk;

  function automatic logic [15:0] pos16(input logic [POSITION_BITS-1:0] v);
    logic [47:0] w;
    w = 48'(v);
    return (w > 48'd65535) ? 16'hFFFF : w[15:0];
  endfunction

  function automatic ev_t mk(input logic [1:0] e, input tok_t t, input logic [7:0] b,
                             input logic bg, input logic [POSITION_BITS-1:0] l,
                             input logic [POSITION_BITS-1:0] c);
    ev_t r;
    r.ek   = e;
    r.tk   = t;
    r.tb   = b;
    r.ln   = bg ? pos16(l) : 16'd0;
    r.cl   = bg ? pos16(c) : 16'd0;
    r.last = 1'b0;
    return r;
  endfunction

  always_comb begin
    md = md_r; hc = hc_r; dp = dp_r; qc = qc_r; lc = lc_r; cc = cc_r; cp = cp_r;
    n = 3'd0; gi = 1'b0; done = 1'b0; matched = 1'b0; stop = 1'b0; skip = 1'b0;
    k = TK_EOF; h = 8'd0; ch = char_code;
    ob = op_base(8'd0); sk = single_kind(ch);
    for (int i = 0; i < 8; i++) evs[i] = '0;
    if (end_of_input) begin
      case (md)
        MD_OP: begin
          ob = op_base(hc);
          if (hc == CH_MINUS) begin ob.found = 1'b1; ob.kind = TK_MINUS; end
          if (hc == CH_SLASH) begin ob.found = 1'b1; ob.kind = TK_SLASH; end
          if (hc == CH_DOT)   begin ob.found = 1'b1; ob.kind = TK_DOT;   end
          if (ob.found) begin
            evs[n] = mk(EV_BEGIN, ob.kind, 8'd0, 1'b1, lc, cc); n = n + 3'd1;
            evs[n] = mk(EV_END, ob.kind, 8'd0, 1'b0, lc, cc);   n = n + 3'd1;
          end
        end
        MD_DOT2: begin
          evs[n] = mk(EV_BEGIN, TK_DOT2, 8'd0, 1'b1, lc, cc); n = n + 3'd1;
          evs[n] = mk(EV_END, TK_DOT2, 8'd0, 1'b0, lc, cc);   n = n + 3'd1;
        end
        MD_LINE, MD_QUOTE, MD_BLOCK: begin
          if (cp) begin
            evs[n] = mk(EV_TEXT, mode_kind(md, qc), CH_CR, 1'b0, lc, cc); n = n + 3'd1;
          end
          if (md == MD_BLOCK && hc != 8'd0) begin
            evs[n] = mk(EV_TEXT, mode_kind(md, qc), hc, 1'b0, lc, cc); n = n + 3'd1;
          end
          evs[n] = mk(EV_END, mode_kind(md, qc), 8'd0, 1'b0, lc, cc); n = n + 3'd1;
        end
        MD_STR, MD_NUM, MD_IDENT, MD_CHRSEQ: begin
          evs[n] = mk(EV_END, mode_kind(md, qc), 8'd0, 1'b0, lc, cc); n = n + 3'd1;
        end
        default: ;
      endcase
      md = MD_IDLE; hc = 8'd0; dp = '0; qc = 8'd0; cp = 1'b0;
      evs[n] = mk(EV_BEGIN, TK_EOF, 8'd0, 1'b1, lc, cc); n = n + 3'd1;
      evs[n] = mk(EV_END, TK_EOF, 8'd0, 1'b0, lc, cc);   n = n + 3'd1;
    end else begin
      case (md)
        MD_IDLE: begin
          if (cp) begin
            cp = 1'b0;
            if (ch == CH_LF) skip = 1'b1;
          end
          if (!skip) begin
            if (cc != PMAX) cc = cc + 1'b1;
            gi = 1'b1;
          end
        end
        MD_OP: begin
          h = hc; md = MD_IDLE; hc = 8'd0;
          if ((h == CH_MINUS || h == CH_DOT) && is_digit(ch)) begin
            evs[n] = mk(EV_BEGIN, TK_NUMBER, 8'd0, 1'b1, lc, cc); n = n + 3'd1;
            evs[n] = mk(EV_TEXT, TK_NUMBER, h, 1'b0, lc, cc);     n = n + 3'd1;
            if (cc != PMAX) cc = cc + 1'b1;
            evs[n] = mk(EV_TEXT, TK_NUMBER, ch, 1'b0, lc, cc);    n = n + 3'd1;
            md = MD_NUM;
            done = 1'b1;
          end else if (h == CH_MINUS) begin
            if (ch == CH_MINUS)   begin k = TK_DEC;    matched = 1'b1; end
            else if (ch == CH_EQ) begin k = TK_SUB_EQ; matched = 1'b1; end
            else if (ch == CH_GT) begin k = TK_ARROW;  matched = 1'b1; end
            else k = TK_MINUS;
          end else if (h == CH_SLASH) begin
            if (ch == CH_EQ) begin k = TK_DIV_EQ; matched = 1'b1; end
            else if (ch == CH_SLASH || ch == CH_STAR) begin
              if (cc != PMAX) cc = cc + 1'b1;
              md = (ch == CH_SLASH) ? MD_LINE : MD_BLOCK;
              dp = NEST_BITS'(1);
              evs[n] = mk(EV_BEGIN, mode_kind(md, qc), 8'd0, 1'b1, lc, cc); n = n + 3'd1;
              done = 1'b1;
            end else k = TK_SLASH;
          end else if (h == CH_DOT) begin
            if (ch == CH_DOT) begin
              if (cc != PMAX) cc = cc + 1'b1;
              md = MD_DOT2;
              done = 1'b1;
            end else k = TK_DOT;
          end else begin
            ob = op_base(h);
            k = ob.kind;
            if (!ob.found) begin
              if (cc != PMAX) cc = cc + 1'b1;
              gi = 1'b1;
              done = 1'b1;
            end else if (ob.three) begin
              if (ch == CH_EQ)  begin k = ob.kind + 6'd2; matched = 1'b1; end
              else if (ch == h) begin k = ob.kind + 6'd1; matched = 1'b1; end
            end else if (ch == ((h == CH_AT) ? CH_AT : CH_EQ)) begin
              k = ob.kind + 6'd1; matched = 1'b1;
            end
          end
          if (!done) begin
            if (matched && cc != PMAX) cc = cc + 1'b1;
            evs[n] = mk(EV_BEGIN, k, 8'd0, 1'b1, lc, cc); n = n + 3'd1;
            evs[n] = mk(EV_END, k, 8'd0, 1'b0, lc, cc);   n = n + 3'd1;
            if (!matched) begin
              if (cc != PMAX) cc = cc + 1'b1;
              gi = 1'b1;
            end
          end
        end
        MD_DOT2: begin
          if (ch == CH_DOT) begin
            if (cc != PMAX) cc = cc + 1'b1;
            evs[n] = mk(EV_BEGIN, TK_DOT3, 8'd0, 1'b1, lc, cc); n = n + 3'd1;
            evs[n] = mk(EV_END, TK_DOT3, 8'd0, 1'b0, lc, cc);   n = n + 3'd1;
            md = MD_IDLE;
          end else begin
            evs[n] = mk(EV_BEGIN, TK_DOT2, 8'd0, 1'b1, lc, cc); n = n + 3'd1;
            evs[n] = mk(EV_END, TK_DOT2, 8'd0, 1'b0, lc, cc);   n = n + 3'd1;
            if (cc != PMAX) cc = cc + 1'b1;
            gi = 1'b1;
          end
        end
        MD_LINE, MD_QUOTE, MD_BLOCK: begin
          if (cp) begin
            cp = 1'b0;
            if (ch == CH_LF) begin
              evs[n] = mk(EV_TEXT, mode_kind(md, qc), CH_LF, 1'b0, lc, cc); n = n + 3'd1;
              stop = 1'b1;
            end else begin
              evs[n] = mk(EV_TEXT, mode_kind(md, qc), CH_CR, 1'b0, lc, cc); n = n + 3'd1;
            end
          end
          if (!stop) begin
            if (cc != PMAX) cc = cc + 1'b1;
            if (md != MD_BLOCK) begin
              if (ch == CH_LF) begin
                evs[n] = mk(EV_END, mode_kind(md, qc), 8'd0, 1'b0, lc, cc); n = n + 3'd1;
                gi = 1'b1;
              end else skip = 1'b1;
            end else begin
              if (hc == CH_SLASH) begin
                hc = 8'd0;
                if (ch == CH_STAR) begin
                  if (dp != NMAX) dp = dp + 1'b1;
                  done = 1'b1;
                end else begin
                  evs[n] = mk(EV_TEXT, mode_kind(md, qc), CH_SLASH, 1'b0, lc, cc);
                  n = n + 3'd1;
                end
              end else if (hc == CH_STAR) begin
                hc = 8'd0;
                if (ch == CH_SLASH) begin
                  if (dp != '0) dp = dp - 1'b1;
                  if (dp == '0) begin
                    evs[n] = mk(EV_END, mode_kind(md, qc), 8'd0, 1'b0, lc, cc);
                    n = n + 3'd1;
                    md = MD_IDLE;
                  end
                  done = 1'b1;
                end else begin
                  evs[n] = mk(EV_TEXT, mode_kind(md, qc), CH_STAR, 1'b0, lc, cc);
                  n = n + 3'd1;
                end
              end else hc = 8'd0;
              if (!done) begin
                if (ch == CH_SLASH || ch == CH_STAR) hc = ch;
                else skip = 1'b1;
              end
            end
            // Body character of a comment or backtick quote.
            if (skip) begin
              if (ch == CH_CR) begin
                if (lc != PMAX) lc = lc + 1'b1;
                cc = '0;
                cp = 1'b1;
              end else begin
                if (ch == CH_LF) begin
                  if (lc != PMAX) lc = lc + 1'b1;
                  cc = '0;
                end
                evs[n] = mk(EV_TEXT, mode_kind(md, qc), ch, 1'b0, lc, cc); n = n + 3'd1;
              end
            end
          end
        end
        MD_STR: begin
          if (cc != PMAX) cc = cc + 1'b1;
          if (ch == qc) begin
            evs[n] = mk(EV_END, mode_kind(md, qc), 8'd0, 1'b0, lc, cc); n = n + 3'd1;
            md = MD_IDLE;
          end else begin
            evs[n] = mk(EV_TEXT, mode_kind(md, qc), ch, 1'b0, lc, cc); n = n + 3'd1;
          end
        end
        MD_NUM, MD_IDENT: begin
          if ((md == MD_NUM) ? (is_ident(ch) || ch == CH_DOT) : is_ident(ch)) begin
            if (cc != PMAX) cc = cc + 1'b1;
            evs[n] = mk(EV_TEXT, mode_kind(md, qc), ch, 1'b0, lc, cc); n = n + 3'd1;
          end else begin
            evs[n] = mk(EV_END, mode_kind(md, qc), 8'd0, 1'b0, lc, cc); n = n + 3'd1;
            if (cc != PMAX) cc = cc + 1'b1;
            gi = 1'b1;
          end
        end
        MD_CHRSEQ: begin
          evs[n] = mk(EV_END, mode_kind(md, qc), 8'd0, 1'b0, lc, cc); n = n + 3'd1;
          if (cc != PMAX) cc = cc + 1'b1;
          gi = 1'b1;
        end
        default: begin
          if (cc != PMAX) cc = cc + 1'b1;
          gi = 1'b1;
        end
      endcase
      // A character seen between tokens; its column is already counted.
      if (gi) begin
        md = MD_IDLE;
        hc = 8'd0;
        ob = op_base(ch);
        if (ch == CH_CR || ch == CH_LF) begin
          evs[n] = mk(EV_BEGIN, TK_LINE_END, 8'd0, 1'b1, lc, cc); n = n + 3'd1;
          evs[n] = mk(EV_END, TK_LINE_END, 8'd0, 1'b0, lc, cc);   n = n + 3'd1;
          if (lc != PMAX) lc = lc + 1'b1;
          cc = '0;
          if (ch == CH_CR) cp = 1'b1;
        end else if (sk.found) begin
          evs[n] = mk(EV_BEGIN, sk.kind, 8'd0, 1'b1, lc, cc); n = n + 3'd1;
          evs[n] = mk(EV_END, sk.kind, 8'd0, 1'b0, lc, cc);   n = n + 3'd1;
        end else if (ob.found || ch == CH_MINUS || ch == CH_SLASH || ch == CH_DOT) begin
          md = MD_OP;
          hc = ch;
        end else if (ch == CH_TICK) begin
          md = MD_QUOTE;
          evs[n] = mk(EV_BEGIN, mode_kind(md, qc), 8'd0, 1'b1, lc, cc); n = n + 3'd1;
        end else if (ch == CH_SQ || ch == CH_DQ) begin
          qc = ch;
          md = MD_STR;
          evs[n] = mk(EV_BEGIN, mode_kind(md, qc), 8'd0, 1'b1, lc, cc); n = n + 3'd1;
        end else if (!is_blank(ch)) begin
          md = is_digit(ch) ? MD_NUM : (is_ident(ch) ? MD_IDENT : MD_CHRSEQ);
          evs[n] = mk(EV_BEGIN, mode_kind(md, qc), 8'd0, 1'b1, lc, cc); n = n + 3'd1;
          evs[n] = mk(EV_TEXT, mode_kind(md, qc), ch, 1'b0, lc, cc);    n = n + 3'd1;
        end
      end
    end
    // At most four results are kept; the last kept one carries the flag.
    res.cnt = (n > 3'd4) ? 3'd4 : n;
    for (int i = 0; i < MAX_EVENTS; i++) begin
      res.evs[i]      = evs[i];
      res.evs[i].last = (3'(i + 1) == res.cnt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      md_r <= MD_IDLE;
      hc_r <= 8'd0;
      dp_r <= '0;
      qc_r <= 8'd0;
      lc_r <= '0;
      cc_r <= '0;
      cp_r <= 1'b0;
    end else if (fire) begin
      md_r <= md;
      hc_r <= hc;
      dp_r <= dp;
      qc_r <= qc;
      lc_r <= lc;
      cc_r <= cc;
      cp_r <= cp;
    end
  end

  `OLX_IMPLY(a_held_only_op_or_block, (md_r != MD_OP && md_r != MD_BLOCK), (hc_r == 8'd0))
  `OLX_IMPLY(a_op_has_held, (md_r == MD_OP), (hc_r != 8'd0))
  `OLX_IMPLY(a_str_has_quote, (md_r == MD_STR), (qc_r == CH_SQ || qc_r == CH_DQ))

endmodule

### hw/rtl/olx_evbuf.sv
`include "operator_lexer_stream_top_macros.svh"

module olx_evbuf (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          load,
  input  olx_pkg::res_t res,
  output logic          load_ok,
  output logic          out_valid,
  input  logic          out_ready,
  output olx_pkg::ev_t  out_ev
);
  import olx_pkg::*;

  ev_t        ev_r [MAX_EVENTS];
  logic [2:0] cnt_r, rd_r;
  logic       pop;

  assign out_valid = (rd_r != cnt_r);
  assign pop       = out_valid && out_ready;
  // A new word may enter while the final result of the previous one leaves.
  assign load_ok   = !out_valid || (pop && (rd_r + 3'd1 == cnt_r));
  assign out_ev    = ev_r[rd_r[1:0]];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 3'd0;
      rd_r  <= 3'd0;
    end else if (load) begin
      cnt_r <= res.cnt;
      rd_r  <= 3'd0;
    end else if (pop) begin
      rd_r <= rd_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < MAX_EVENTS; i++) ev_r[i] <= res.evs[i];
    end
  end

  `OLX_CHECK(a_cnt_bound, (cnt_r <= 3'd4))
  `OLX_CHECK(a_rd_bound, (rd_r <= cnt_r))
  `OLX_IMPLY(a_last_on_final, out_valid, (out_ev.last == (rd_r + 3'd1 == cnt_r)))

endmodule

### hw/rtl/operator_lexer_stream_top.sv
// Channel  Dir  tdata                          tlast
// in_      in   [7:0] char_code                end_of_input
// out_     out  [47:0] event fields (see port) last
//
// One input word is accepted per cycle, unless the output stalls, when it
// causes at most one result; a word with N results sends them in turn.
// The per-character decision is a single combinational pass from the lexer
// state registers into a four-entry result buffer, which drains one word
// per cycle unless stalled. A new input is taken while the final result
// of the previous word is leaving. Reset (rst_n low, synchronous) returns
// the lexer to idle with zero counters and empties the buffer. Output
// stalls hold the buffer and back-pressure the input.
module operator_lexer_stream_top #(
  parameter int NEST_BITS     = olx_pkg::NEST_BITS_DEF,
  parameter int POSITION_BITS = olx_pkg::POSITION_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_code
  input  logic        in_tlast,   // end_of_input
  output logic        out_tvalid,
  input  logic        out_tready,
  // [1:0] event_kind, [7:2] token_kind, [15:8] text_byte,
  // [31:16] line_number, [47:32] column_number
  output logic [47:0] out_tdata,
  output logic        out_tlast   // last
);
  import olx_pkg::*;

  logic fire;
  res_t res;
  ev_t  ev;

  assign fire = in_tvalid && in_tready;

  // The lexer state advances only when a word is accepted.
  olx_lexer #(
    .NEST_BITS    (NEST_BITS),
    .POSITION_BITS(POSITION_BITS)
  ) u_lexer (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (fire),
    .char_code   (in_tdata),
    .end_of_input(in_tlast),
    .res         (res)
  );

  // Result buffer: holds up to four result words of one input until taken.
  olx_evbuf u_evbuf (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (fire),
    .res      (res),
    .load_ok  (in_tready),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_ev   (ev)
  );

  assign out_tdata = {ev.cl, ev.ln, ev.tb, ev.tk, ev.ek};
  assign out_tlast = ev.last;

endmodule
